// ===== rtl/core/fmmpx_pkg.sv =====
// Shared types, constants and tone tables for the FM stereo multiplex generator.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package fmmpx_pkg;

    // sample and composite widths
    localparam int SAMPLE_W   = 12;
    localparam int ACCUM_W    = 26;
    localparam int TDATA_W    = 16;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

    // tone table lengths and pointer widths
    localparam int CARRIER_LEN = 22;
    localparam int PILOT_LEN   = 44;
    localparam int CPTR_W      = 5;
    localparam int PPTR_W      = 6;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEREO_SHIFT = 2'd0,
        CFG_PILOT_MULT   = 2'd1,
        CFG_PILOT_SHIFT  = 2'd2,
        CFG_OUTPUT_SHIFT = 2'd3
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic [4:0] stereo_shift;
        logic [7:0] pilot_mult;
        logic [3:0] pilot_shift;
        logic [3:0] output_shift;
    } t_cfg;

    // 38 kHz carrier, one cycle over the table
    function automatic logic [SAMPLE_W-1:0] carrier_lookup(input logic [CPTR_W-1:0] ptr);
        logic [SAMPLE_W-1:0] v;
        case (ptr)
            5'd0:    v = 12'd2058;
            5'd1:    v = 12'd2637;
            5'd2:    v = 12'd3170;
            5'd3:    v = 12'd3613;
            5'd4:    v = 12'd3930;
            5'd5:    v = 12'd4095;
            5'd6:    v = 12'd4095;
            5'd7:    v = 12'd3930;
            5'd8:    v = 12'd3613;
            5'd9:    v = 12'd3170;
            5'd10:   v = 12'd2637;
            5'd11:   v = 12'd2058;
            5'd12:   v = 12'd1479;
            5'd13:   v = 12'd946;
            5'd14:   v = 12'd503;
            5'd15:   v = 12'd186;
            5'd16:   v = 12'd21;
            5'd17:   v = 12'd21;
            5'd18:   v = 12'd186;
            5'd19:   v = 12'd503;
            5'd20:   v = 12'd946;
            5'd21:   v = 12'd1479;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    // 19 kHz pilot, one cycle over the table
    function automatic logic [SAMPLE_W-1:0] pilot_lookup(input logic [PPTR_W-1:0] ptr);
        logic [SAMPLE_W-1:0] v;
        case (ptr)
            6'd0:    v = 12'd2047;
            6'd1:    v = 12'd2338;
            6'd2:    v = 12'd2623;
            6'd3:    v = 12'd2897;
            6'd4:    v = 12'd3153;
            6'd5:    v = 12'd3387;
            6'd6:    v = 12'd3594;
            6'd7:    v = 12'd3769;
            6'd8:    v = 12'd3909;
            6'd9:    v = 12'd4011;
            6'd10:   v = 12'd4073;
            6'd11:   v = 12'd4094;
            6'd12:   v = 12'd4073;
            6'd13:   v = 12'd4011;
            6'd14:   v = 12'd3909;
            6'd15:   v = 12'd3769;
            6'd16:   v = 12'd3594;
            6'd17:   v = 12'd3387;
            6'd18:   v = 12'd3153;
            6'd19:   v = 12'd2897;
            6'd20:   v = 12'd2623;
            6'd21:   v = 12'd2338;
            6'd22:   v = 12'd2047;
            6'd23:   v = 12'd1756;
            6'd24:   v = 12'd1471;
            6'd25:   v = 12'd1197;
            6'd26:   v = 12'd941;
            6'd27:   v = 12'd707;
            6'd28:   v = 12'd500;
            6'd29:   v = 12'd325;
            6'd30:   v = 12'd185;
            6'd31:   v = 12'd83;
            6'd32:   v = 12'd21;
            6'd33:   v = 12'd0;
            6'd34:   v = 12'd21;
            6'd35:   v = 12'd83;
            6'd36:   v = 12'd185;
            6'd37:   v = 12'd325;
            6'd38:   v = 12'd500;
            6'd39:   v = 12'd707;
            6'd40:   v = 12'd941;
            6'd41:   v = 12'd1197;
            6'd42:   v = 12'd1471;
            6'd43:   v = 12'd1756;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/fmmpx_cfg.sv =====
// Configuration register bank for the FM stereo multiplex generator.
// Depends on fmmpx_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps

module fmmpx_cfg
    import fmmpx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // register writes, low bits of the data taken per register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stereo_shift <= 5'd11;
            r_cfg.pilot_mult   <= 8'd1;
            r_cfg.pilot_shift  <= 4'd1;
            r_cfg.output_shift <= 4'd1;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_STEREO_SHIFT: r_cfg.stereo_shift <= i_wr_data[4:0];
                CFG_PILOT_MULT:   r_cfg.pilot_mult   <= i_wr_data[7:0];
                CFG_PILOT_SHIFT:  r_cfg.pilot_shift  <= i_wr_data[3:0];
                CFG_OUTPUT_SHIFT: r_cfg.output_shift <= i_wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/fmmpx_tone.sv =====
// Carrier and pilot tone generators: wrapping indexes, table pointers and
// registered table values. Depends on fmmpx_pkg for the tables.
`timescale 1ns / 1ps

module fmmpx_tone
    import fmmpx_pkg::*;
#(
    parameter int CARRIER_LAST_INDEX = 21,
    parameter int PILOT_LAST_INDEX   = 43
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    output logic [SAMPLE_W-1:0] o_carrier_value,
    output logic [SAMPLE_W-1:0] o_pilot_value
);

    localparam int CIDX_W = $clog2(CARRIER_LAST_INDEX + 1);
    localparam int PIDX_W = $clog2(PILOT_LAST_INDEX + 1);

    logic [CIDX_W-1:0]   r_cidx, n_cidx;
    logic [PIDX_W-1:0]   r_pidx, n_pidx;
    logic [CPTR_W-1:0]   r_cptr, n_cptr;
    logic [PPTR_W-1:0]   r_pptr, n_pptr;
    logic [SAMPLE_W-1:0] r_carrier, r_pilot;

    // index wraps at its last value; pointer follows it modulo the table length
    always_comb begin
        if (r_cidx == CIDX_W'(CARRIER_LAST_INDEX)) begin
            n_cidx = '0;
            n_cptr = '0;
        end else begin
            n_cidx = r_cidx + 1'b1;
            n_cptr = (r_cptr == CPTR_W'(CARRIER_LEN - 1)) ? '0 : r_cptr + 1'b1;
        end
        if (r_pidx == PIDX_W'(PILOT_LAST_INDEX)) begin
            n_pidx = '0;
            n_pptr = '0;
        end else begin
            n_pidx = r_pidx + 1'b1;
            n_pptr = (r_pptr == PPTR_W'(PILOT_LEN - 1)) ? '0 : r_pptr + 1'b1;
        end
    end

    // step on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cidx    <= '0;
            r_pidx    <= '0;
            r_cptr    <= '0;
            r_pptr    <= '0;
            r_carrier <= '0;
            r_pilot   <= '0;
        end else if (i_step) begin
            r_cidx    <= n_cidx;
            r_pidx    <= n_pidx;
            r_cptr    <= n_cptr;
            r_pptr    <= n_pptr;
            r_carrier <= carrier_lookup(n_cptr);
            r_pilot   <= pilot_lookup(n_pptr);
        end
    end

    assign o_carrier_value = r_carrier;
    assign o_pilot_value   = r_pilot;

endmodule

// ===== rtl/core/fmmpx_mix.sv =====
// Channel level capture and composite builder: sum, carrier-modulated
// difference and scaled pilot. Depends on fmmpx_pkg for widths and t_cfg.
`timescale 1ns / 1ps

module fmmpx_mix
    import fmmpx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_adc_done,
    input  logic [SAMPLE_W-1:0] i_adc_sample,
    input  t_cfg                i_cfg,
    input  logic [SAMPLE_W-1:0] i_carrier_value,
    input  logic [SAMPLE_W-1:0] i_pilot_value,
    output logic [ACCUM_W-1:0]  o_composite,
    output logic                o_channel_next
);

    logic [SAMPLE_W-1:0]   r_right, r_left;
    logic [ACCUM_W-1:0]    r_comp, n_comp;
    logic                  r_chan, n_chan;
    logic                  diff_neg;
    logic [SAMPLE_W-1:0]   absdiff, carr;
    logic [2*SAMPLE_W-1:0] stereo_prod, stereo;
    logic [SAMPLE_W+7:0]   pilot_prod, pilot;
    logic [SAMPLE_W:0]     lr_sum;

    // composite from the levels and tone values held before this item
    always_comb begin
        diff_neg    = r_right < r_left;
        absdiff     = diff_neg ? (r_left - r_right) : (r_right - r_left);
        carr        = diff_neg ? (FULL_SCALE - i_carrier_value) : i_carrier_value;
        stereo_prod = (2*SAMPLE_W)'(absdiff) * (2*SAMPLE_W)'(carr);
        stereo      = stereo_prod >> i_cfg.stereo_shift;
        pilot_prod  = (SAMPLE_W+8)'(i_pilot_value) * (SAMPLE_W+8)'(i_cfg.pilot_mult);
        pilot       = pilot_prod >> i_cfg.pilot_shift;
        lr_sum      = {1'b0, r_left} + {1'b0, r_right};
        n_comp      = ACCUM_W'(lr_sum) + ACCUM_W'(stereo) + ACCUM_W'(pilot);
        n_chan      = i_adc_done ? ~r_chan : r_chan;
    end

    // right first, then left, alternating on each finished conversion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= '0;
            r_left  <= '0;
            r_comp  <= '0;
            r_chan  <= 1'b0;
        end else if (i_step) begin
            if (i_adc_done) begin
                if (!r_chan) begin
                    r_right <= i_adc_sample;
                end else begin
                    r_left <= i_adc_sample;
                end
            end
            r_comp <= n_comp;
            r_chan <= n_chan;
        end
    end

    assign o_composite    = r_comp;
    assign o_channel_next = n_chan;

endmodule

// ===== rtl/core/fm_stereo_mpx_generator.sv =====
// FM stereo multiplex generator: one composite DAC sample per accepted item.
// The result is registered in the output register when the item is accepted.
// Throughput: one item per cycle unless m_axis_tready stalls the output; the
// output register takes a new result in the same cycle that the previous one is taken.
// Reset (synchronous, active low) clears levels, composite, tone state,
// channel select and output valid, and loads the register defaults.
`timescale 1ns / 1ps

module fm_stereo_mpx_generator
    import fmmpx_pkg::*;
#(
    parameter int CARRIER_LAST_INDEX = 21,
    parameter int PILOT_LAST_INDEX   = 43
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,  // [11:0] adc_sample, [15:12] zero
    input  logic [0:0]            s_axis_tuser,  // [0] adc_done
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,  // [11:0] dac_value, [15:12] zero
    output logic [0:0]            m_axis_tuser   // [0] adc_channel_next
);

    t_cfg                cfg;
    logic                step;
    logic [SAMPLE_W-1:0] carrier_value, pilot_value;
    logic [ACCUM_W-1:0]  composite;
    logic                chan_next;
    logic [ACCUM_W-1:0]  comp_shift;
    logic [SAMPLE_W-1:0] n_dac;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_dac;
    logic                r_chan;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    fmmpx_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    fmmpx_tone #(
        .CARRIER_LAST_INDEX (CARRIER_LAST_INDEX),
        .PILOT_LAST_INDEX   (PILOT_LAST_INDEX)
    ) u_tone (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .o_carrier_value (carrier_value),
        .o_pilot_value   (pilot_value)
    );

    fmmpx_mix u_mix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_adc_done      (s_axis_tuser[0]),
        .i_adc_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_cfg           (cfg),
        .i_carrier_value (carrier_value),
        .i_pilot_value   (pilot_value),
        .o_composite     (composite),
        .o_channel_next  (chan_next)
    );

    // previous composite scaled down and saturated to the dac range
    always_comb begin
        comp_shift = composite >> cfg.output_shift;
        n_dac      = (|comp_shift[ACCUM_W-1:SAMPLE_W]) ? FULL_SCALE
                                                       : comp_shift[SAMPLE_W-1:0];
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_dac  <= n_dac;
            r_chan <= chan_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W - SAMPLE_W){1'b0}}, r_dac};
    assign m_axis_tuser  = r_chan;

endmodule
